>>> hdl/ftsa_pkg.sv
`default_nettype none

package ftsa_pkg;

    localparam int TIME_W    = 63;
    localparam int DUR_W     = 32;
    localparam int IDX_W     = 64;
    localparam int LOST_W    = 32;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 63;

    localparam logic [DUR_W-1:0] DUR_RESET = 32'd33333333;

    // result status codes
    localparam logic [STAT_W-1:0] ST_IN_ORDER  = 2'd0;
    localparam logic [STAT_W-1:0] ST_DISCONT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_SKIPPED   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BACKWARDS = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE,
        S_DUR,
        S_CHECK,
        S_DIV,
        S_RND1,
        S_RND2,
        S_UPD,
        S_OUT
    } t_seq_state;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [DUR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
        logic [DUR_W-1:0]  remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> hdl/ftsa_divider.sv
`default_nettype none

module ftsa_divider
    import ftsa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(TIME_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TIME_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TIME_W-1:0] r_q, n_q;
    logic [DUR_W-1:0]  r_rem, n_rem;
    logic [DUR_W-1:0]  r_d, n_d;

    logic [DUR_W:0] w_shift;
    logic [DUR_W:0] w_diff;

    // one restoring step per cycle, dividend shifts out as quotient shifts in
    always_comb begin
        w_shift = {r_rem, r_q[TIME_W-1]};
        w_diff  = w_shift - {1'b0, r_d};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_d     = r_d;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_req.dividend;
            n_rem  = '0;
            n_d    = i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[DUR_W]) begin
                n_rem = w_diff[DUR_W-1:0];
                n_q   = {r_q[TIME_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DUR_W-1:0];
                n_q   = {r_q[TIME_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

>>> hdl/frame_timestamp_aligner_unit.sv
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_clock_now
// out       output     o_out_valid / i_out_ready  o_status, o_frame_time,
//                                                 o_frame_index, o_lost_frames
// cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// a frame goes from accept to result register through the base, duration and
// check states, the 63 steps of the restoring divider (one quotient bit per
// cycle), rounding and update; first and backwards frames skip the divider.
// o_in_ready is high only while the sequencer is idle.
// a finished word waits in the output register; a new frame is accepted
// meanwhile, and the sequencer holds its next result until that word is taken.
// reset is synchronous active low and restores the register defaults.
`default_nettype none

module frame_timestamp_aligner_unit
    import ftsa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [TIME_W-1:0]    i_clock_now,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [STAT_W-1:0]         o_status,
    output logic [TIME_W-1:0]         o_frame_time,
    output logic [IDX_W-1:0]          o_frame_index,
    output logic [LOST_W-1:0]         o_lost_frames,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_seq_state r_state, n_state;

    logic [DUR_W-1:0]  r_dur;
    logic [TIME_W-1:0] r_base;
    logic              r_have, n_have;
    logic [TIME_W-1:0] r_prev, n_prev;
    logic [IDX_W-1:0]  r_offset, n_offset;

    logic [TIME_W-1:0] r_t, n_t;
    logic [TIME_W-1:0] r_q, n_q;
    logic [DUR_W-1:0]  r_rem, n_rem;
    logic [DUR_W-1:0]  r_up, n_up;
    logic              r_fdown, n_fdown;
    logic [IDX_W-1:0]  r_cnt, n_cnt;

    logic [STAT_W-1:0] r_res_st, n_res_st;
    logic [TIME_W-1:0] r_res_ft, n_res_ft;
    logic [IDX_W-1:0]  r_res_fi, n_res_fi;
    logic [LOST_W-1:0] r_res_lf, n_res_lf;

    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_o_st, n_o_st;
    logic [TIME_W-1:0] r_o_ft, n_o_ft;
    logic [IDX_W-1:0]  r_o_fi, n_o_fi;
    logic [LOST_W-1:0] r_o_lf, n_o_lf;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic [DUR_W-1:0]  w_dur;
    logic [TIME_W:0]   w_sub;
    logic [DUR_W+2:0]  w_rem3;
    logic [TIME_W:0]   w_sum;
    logic              w_down;
    logic [IDX_W-1:0]  w_lost64;
    logic [IDX_W-1:0]  w_new_off;

    ftsa_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // a zero duration register acts as one
    assign w_dur = (r_dur == '0) ? DUR_W'(1) : r_dur;

    always_comb begin
        n_state     = r_state;
        n_have      = r_have;
        n_prev      = r_prev;
        n_offset    = r_offset;
        n_t         = r_t;
        n_q         = r_q;
        n_rem       = r_rem;
        n_up        = r_up;
        n_fdown     = r_fdown;
        n_cnt       = r_cnt;
        n_res_st    = r_res_st;
        n_res_ft    = r_res_ft;
        n_res_fi    = r_res_fi;
        n_res_lf    = r_res_lf;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_st      = r_o_st;
        n_o_ft      = r_o_ft;
        n_o_fi      = r_o_fi;
        n_o_lf      = r_o_lf;
        w_req.start    = 1'b0;
        w_req.dividend = r_t - r_prev;
        w_req.divisor  = w_dur;
        w_sub     = '0;
        w_rem3    = ({3'b000, r_rem} + {2'b00, r_rem, 1'b0}) + (DUR_W+3)'(3);
        w_sum     = {1'b0, r_t} + {{(TIME_W+1-DUR_W){1'b0}}, r_up};
        w_down    = r_fdown || w_sum[TIME_W];
        w_lost64  = r_cnt - IDX_W'(1);
        w_new_off = r_offset + r_cnt;
        o_in_ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_t     = i_clock_now;
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                // saturating subtract of the base time
                w_sub   = {1'b0, r_t} - {1'b0, r_base};
                n_t     = w_sub[TIME_W] ? '0 : w_sub[TIME_W-1:0];
                n_state = S_DUR;
            end
            S_DUR: begin
                w_sub   = {1'b0, r_t} - {{(TIME_W+1-DUR_W){1'b0}}, w_dur};
                n_t     = w_sub[TIME_W] ? '0 : w_sub[TIME_W-1:0];
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_res_fi = r_offset;
                n_res_lf = '0;
                if (!r_have) begin
                    n_have   = 1'b1;
                    n_prev   = r_t;
                    n_res_st = ST_IN_ORDER;
                    n_res_ft = r_t;
                    n_state  = S_OUT;
                end else if (r_t < r_prev) begin
                    n_res_st = ST_BACKWARDS;
                    n_res_ft = '0;
                    n_state  = S_OUT;
                end else begin
                    w_req.start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    n_q     = w_rsp.quotient;
                    n_rem   = w_rsp.remainder;
                    n_state = S_RND1;
                end
            end
            S_RND1: begin
                // rem < dur/3 is the same as 3*(rem+1) <= dur
                n_up    = w_dur - r_rem;
                n_fdown = (w_rem3 <= {3'b000, w_dur});
                n_state = S_RND2;
            end
            S_RND2: begin
                // rounding up past the time range falls back to rounding down
                if (w_down) begin
                    n_t   = r_t - {{(TIME_W-DUR_W){1'b0}}, r_rem};
                    n_cnt = {1'b0, r_q};
                end else begin
                    n_t   = w_sum[TIME_W-1:0];
                    n_cnt = {1'b0, r_q} + IDX_W'(1);
                end
                n_state = S_UPD;
            end
            S_UPD: begin
                if (r_cnt == '0) begin
                    n_res_st = ST_SKIPPED;
                    n_res_ft = '0;
                    n_res_fi = r_offset;
                    n_res_lf = '0;
                end else begin
                    n_res_st = (r_cnt == IDX_W'(1)) ? ST_IN_ORDER : ST_DISCONT;
                    n_res_ft = r_t;
                    n_res_fi = w_new_off;
                    n_res_lf = (w_lost64[IDX_W-1:LOST_W] != '0) ? '1
                                                              : w_lost64[LOST_W-1:0];
                    n_offset = w_new_off;
                    n_prev   = r_t;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_st      = r_res_st;
                    n_o_ft      = r_res_ft;
                    n_o_fi      = r_res_fi;
                    n_o_lf      = r_res_lf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dur       <= DUR_RESET;
            r_base      <= '0;
            r_have      <= 1'b0;
            r_prev      <= '0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have      <= n_have;
            r_prev      <= n_prev;
            r_offset    <= n_offset;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DURATION: r_dur  <= i_cfg_data[DUR_W-1:0];
                    CFG_BASE:     r_base <= i_cfg_data[TIME_W-1:0];
                    default:      r_base <= r_base;
                endcase
            end
        end
        r_t      <= n_t;
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_up     <= n_up;
        r_fdown  <= n_fdown;
        r_cnt    <= n_cnt;
        r_res_st <= n_res_st;
        r_res_ft <= n_res_ft;
        r_res_fi <= n_res_fi;
        r_res_lf <= n_res_lf;
        r_o_st   <= n_o_st;
        r_o_ft   <= n_o_ft;
        r_o_fi   <= n_o_fi;
        r_o_lf   <= n_o_lf;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_st;
    assign o_frame_time  = r_o_ft;
    assign o_frame_index = r_o_fi;
    assign o_lost_frames = r_o_lf;

endmodule

`default_nettype wire

>>> hdl/ftsa_checker.sv
`default_nettype none

module ftsa_checker
    import ftsa_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire logic [TIME_W-1:0]    i_clock_now,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [STAT_W-1:0]    o_status,
    input wire logic [TIME_W-1:0]    o_frame_time,
    input wire logic [IDX_W-1:0]     o_frame_index,
    input wire logic [LOST_W-1:0]    o_lost_frames,
    input wire logic                 i_cfg_we,
    input wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input wire logic [CFG_W-1:0]     i_cfg_data
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_frame_time) && $stable(o_frame_index)
            && $stable(o_lost_frames))
        else $error("output word changed while stalled");

    // the sequencer is not ready again in the cycle after it accepts a frame
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on back to back cycles");

    // skipped and backwards frames carry no time and no loss
    a_reject_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_SKIPPED || o_status == ST_BACKWARDS)
            |-> o_frame_time == '0 && o_lost_frames == '0)
        else $error("rejected frame with nonzero time or loss");

    // loss count agrees with the status
    a_lost_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_DISCONT) == (o_lost_frames != '0))
        else $error("lost count does not match status");

endmodule

bind frame_timestamp_aligner_unit ftsa_checker u_ftsa_checker (.*);

`default_nettype wire

>>> bench/tb_frame_timestamp_aligner_unit.sv
`default_nettype none

module tb_frame_timestamp_aligner_unit;
    import ftsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 800_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ROUND_THIRDS  = 3;
    localparam int MAX_GAP       = 17;

    localparam logic [63:0]       TOP_TIME  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]       LOST_CAP  = 64'hFFFF_FFFF;
    localparam logic [TIME_W-1:0] TOP_CLOCK = '1;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TIME_W-1:0] ftime;
        logic [IDX_W-1:0]  index;
        logic [LOST_W-1:0] lost;
    } t_stamp;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [TIME_W-1:0]  clock_now = '0;
    logic               out_ready = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    logic               in_ready;
    logic               out_valid;
    logic [STAT_W-1:0]  status;
    logic [TIME_W-1:0]  frame_time;
    logic [IDX_W-1:0]   frame_index;
    logic [LOST_W-1:0]  lost_frames;

    // aligner state as the bench sees it
    logic               seen_frame  = 1'b0;
    logic [TIME_W-1:0]  last_time   = '0;
    logic [IDX_W-1:0]   frame_count = '0;
    logic [DUR_W-1:0]   cur_dur     = DUR_RESET;
    logic [TIME_W-1:0]  cur_base    = '0;

    t_stamp      pending_stamps[$];
    int          failures     = 0;
    int          reg_writes   = 0;
    int          status_seen[4];
    int unsigned cycle_count  = 0;
    bit          idle_in      = 1'b1;
    bit          idle_out     = 1'b1;
    int          hold_len     = 0;

    frame_timestamp_aligner_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_clock_now   (clock_now),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (status),
        .o_frame_time  (frame_time),
        .o_frame_index (frame_index),
        .o_lost_frames (lost_frames),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_stamps.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [63:0] eff_duration();
        return (cur_dur == '0) ? 64'd1 : {32'd0, cur_dur};
    endfunction

    function automatic logic [TIME_W-1:0] rand_clock();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    // snaps one frame onto the duration grid and advances the state
    function automatic t_stamp align_frame(input logic [TIME_W-1:0] now);
        logic [63:0] d, t, rem, cnt, lost64;
        t_stamp      r;
        d = eff_duration();
        t = (now > cur_base) ? {1'b0, now - cur_base} : 64'd0;
        t = (t > d) ? t - d : 64'd0;
        r = '0;
        r.status = ST_IN_ORDER;
        if (!seen_frame) begin
            seen_frame = 1'b1;
            last_time  = t[TIME_W-1:0];
            r.ftime    = t[TIME_W-1:0];
        end else if (t < {1'b0, last_time}) begin
            r.status = ST_BACKWARDS;
        end else begin
            rem = (t - {1'b0, last_time}) % d;
            // round up only if the grid point stays inside the time range
            if (rem < d / ROUND_THIRDS || (d - rem) > (TOP_TIME - t))
                t = t - rem;
            else
                t = t + (d - rem);
            cnt = (t - {1'b0, last_time}) / d;
            if (cnt == 0) begin
                r.status = ST_SKIPPED;
            end else begin
                if (cnt > 1) begin
                    r.status = ST_DISCONT;
                    lost64   = cnt - 1;
                    r.lost   = (lost64 > LOST_CAP) ? LOST_CAP[LOST_W-1:0] : lost64[LOST_W-1:0];
                end
                frame_count = frame_count + cnt;
                last_time   = t[TIME_W-1:0];
                r.ftime     = t[TIME_W-1:0];
            end
        end
        r.index = frame_count;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk) begin : word_check
        t_stamp want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_stamps.size() == 0) begin
                $display("%0t: unexpected word, expected none, got status %0d time %0d",
                         $time, status, frame_time);
                failures++;
            end else begin
                want = pending_stamps.pop_front();
                status_seen[want.status]++;
                compare_field("status", 64'(want.status), 64'(status));
                compare_field("frame_time", 64'(want.ftime), 64'(frame_time));
                compare_field("frame_index", want.index, frame_index);
                compare_field("lost_frames", 64'(want.lost), 64'(lost_frames));
            end
        end
    end

    // result side: random stalls per word, plus one long hold on request
    initial begin : result_sink
        int gap;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = idle_out ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_len > 0) begin
                gap      = hold_len;
                hold_len = 0;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    task automatic send_frame(input logic [TIME_W-1:0] now);
        int gap;
        gap = idle_in ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        clock_now <= now;
        do @(posedge clk); while (!in_ready);
        pending_stamps.push_back(align_frame(now));
    endtask

    // clock reading whose raw time (after base and one duration) is t
    task automatic send_at(input logic [63:0] t);
        logic [63:0] now;
        now = t + eff_duration() + {1'b0, cur_base};
        send_frame(now[TIME_W-1:0]);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_stamps.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_DURATION)
            cur_dur = data[DUR_W-1:0];
        else
            cur_base = data;
        reg_writes++;
    endtask

    // mostly well-formed streams around the previous frame, some noise and reversals
    task automatic run_stream(input int frames);
        logic [63:0] d, t, j, m, now;
        int          pick;
        for (int n = 0; n < frames; n++) begin
            d    = eff_duration();
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                now = {$urandom, $urandom} & 64'h0000_FFFF_FFFF_FFFF;
            end else if (pick >= 95 && last_time > 1000) begin
                t   = {1'b0, last_time} - 64'($urandom_range(1, 1000));
                now = t + d + {1'b0, cur_base};
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    // land right at the one-third rounding point
                    j = d / ROUND_THIRDS + 64'($urandom_range(0, 2));
                    if (j != 0)
                        j = j - 1;
                end else begin
                    j = {32'd0, $urandom} % d;
                end
                if (pick < 15)
                    m = 64'd0;
                else if (pick < 25)
                    m = 64'($urandom_range(2, 6));
                else
                    m = 64'd1;
                t   = {1'b0, last_time} + m * d + j;
                now = t + d + {1'b0, cur_base};
            end
            send_frame(now[TIME_W-1:0]);
        end
    endtask

    task automatic test_directed();
        logic [63:0] d;
        d = eff_duration();
        send_frame('0);                         // first frame, raw time clamps to zero
        send_at(d);
        send_at(2 * d + d / ROUND_THIRDS - 1);  // just under a third rounds down
        send_at(3 * d + d / ROUND_THIRDS);      // exactly a third rounds up, one lost
        send_at(4 * d + 5);
        send_at(4 * d - 7);
        send_at(10 * d);
        send_frame(d[TIME_W-1:0]);              // duration subtraction saturates
        wait_drained();
        write_reg(CFG_BASE, 63'd5000);
        send_frame(63'd4000);                   // clock below base
        send_at(11 * d);
        wait_drained();
        // zero duration behaves as one, upper data bits are don't-care
        write_reg(CFG_DURATION, rand_clock() & ~63'hFFFF_FFFF);
        send_at({1'b0, last_time} + 1);
        send_at({1'b0, last_time} + 64'h2_0000_0000);
        wait_drained();
        write_reg(CFG_DURATION, 63'd3);
        send_at({1'b0, last_time} + 3);
        send_at({1'b0, last_time} + 4);
        wait_drained();
        write_reg(CFG_DURATION, 63'hFFFF_FFFF);
        d = eff_duration();
        send_at({1'b0, last_time} + 2 * d + d / ROUND_THIRDS);
        send_at({1'b0, last_time} + d + d / ROUND_THIRDS - 1);
        wait_drained();
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] dur_data;
        logic [CFG_W-1:0] base_data;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: dur_data = 63'd1;
                1: dur_data = 63'd2;
                2: dur_data = rand_clock();
                3: dur_data = 63'hFFFF_FFFF;
                4: dur_data = 63'($urandom_range(4, 100));
                default: dur_data = {31'd0, $urandom};
            endcase
            base_data = (ph % 2 == 0) ? '0 : rand_clock() & 63'h00FF_FFFF_FFFF;
            write_reg(CFG_DURATION, dur_data);
            write_reg(CFG_BASE, base_data);
            idle_in  = (ph != 2 && ph != 4);
            idle_out = (ph != 2 && ph != 3);
            run_stream(150);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        idle_in  = 1'b0;
        idle_out = 1'b0;
        write_reg(CFG_DURATION, 63'd50);
        hold_len = 800;
        run_stream(25);
        wait_drained();
        idle_in  = 1'b1;
        idle_out = 1'b1;
    endtask

    // pushes the previous time to the top of the range, so it runs last
    task automatic test_top_of_range();
        write_reg(CFG_BASE, '0);
        write_reg(CFG_DURATION, {31'd0, $urandom});
        send_frame(TOP_CLOCK);
        repeat (15) send_frame(rand_clock());
        send_frame(TOP_CLOCK);
        wait_drained();
        write_reg(CFG_BASE, rand_clock());
        repeat (8) send_frame(rand_clock());
        wait_drained();
        write_reg(CFG_BASE, TOP_CLOCK);
        write_reg(CFG_DURATION, '0);
        repeat (5) send_frame(rand_clock());
        send_frame(TOP_CLOCK);
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_phases();
        test_backpressure();
        test_top_of_range();
        $display("aligned %0d frames: %0d in order, %0d discontinuous, %0d skipped, %0d backwards",
                 status_seen[ST_IN_ORDER] + status_seen[ST_DISCONT] + status_seen[ST_SKIPPED]
                 + status_seen[ST_BACKWARDS], status_seen[ST_IN_ORDER],
                 status_seen[ST_DISCONT], status_seen[ST_SKIPPED], status_seen[ST_BACKWARDS]);
        $display("%0d register writes, durations from zero to full scale, bases up to the top",
                 reg_writes);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
